### design/u2c_pkg.sv
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned HOLD_N  = 3;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 24;

  // default depth of the queue between front and back
  localparam int unsigned U2C_QUEUE_DEPTH = 2;

  // byte constants
  localparam logic [BYTE_W-1:0] LEAD_F4   = 8'hf4;
  localparam logic [BYTE_W-1:0] LEAD_F0   = 8'hf0;
  localparam logic [2:0]        PFX_LEAD2 = 3'b110;
  localparam logic [3:0]        PFX_LEAD3 = 4'b1110;
  localparam logic [1:0]        PFX_CONT  = 2'b10;
  localparam logic [3:0]        PFX_CONT_F4 = 4'h8;

  // continuation counts of a pending sequence
  localparam logic [1:0] EXP_NONE = 2'd0;
  localparam logic [1:0] EXP_ONE  = 2'd1;
  localparam logic [1:0] EXP_TWO  = 2'd2;
  localparam logic [1:0] EXP_THREE = 2'd3;

  // One job: nr_raw raw bytes (flagged) first, then an optional tail result.
  typedef struct packed {
    logic [HOLD_N-1:0][BYTE_W-1:0] raw;
    logic [1:0]                    nr_raw;
    logic                          tail_vld;
    logic [CP_W-1:0]               tail_cp;
    logic                          tail_err;
  } job_t;

  // front status, seen by the top level checks
  typedef struct packed {
    logic idle;
  } front_stat_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### design/u2c_front.sv
// ----------------------------------------------------------------------------
// u2c_front
// Accepts bytes, tracks the pending sequence and turns each byte that yields a result into a job.
// ----------------------------------------------------------------------------
module u2c_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [u2c_pkg::BYTE_W-1:0]  byte_i,
  input  logic                        end_i,
  output logic                        push_o,
  output u2c_pkg::job_t               job_o,
  output u2c_pkg::front_stat_t        stat_o
);
  import u2c_pkg::*;

  logic [HOLD_N-1:0][BYTE_W-1:0] held_q, held_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] exp_q, exp_d;

  logic       is_ascii, is_lead2, is_lead3, is_lead4, is_lead;
  logic [1:0] fresh_exp;
  logic       cont_ok;
  logic [CP_W-1:0] cp;

  // classify the incoming byte as a fresh start
  always_comb begin
    is_ascii = ~byte_i[7];
    is_lead2 = (byte_i[7:5] == PFX_LEAD2);
    is_lead3 = (byte_i[7:4] == PFX_LEAD3);
    is_lead4 = (byte_i >= LEAD_F0) && (byte_i <= LEAD_F4);
    is_lead  = is_lead2 | is_lead3 | is_lead4;
    if (is_lead2) begin
      fresh_exp = EXP_ONE;
    end else if (is_lead3) begin
      fresh_exp = EXP_TWO;
    end else begin
      fresh_exp = EXP_THREE;
    end
  end

  // continuation check; F4 restricts its first continuation to 80-8F
  always_comb begin
    if (cnt_q == 2'd1 && held_q[0] == LEAD_F4) begin
      cont_ok = (byte_i[7:4] == PFX_CONT_F4);
    end else begin
      cont_ok = (byte_i[7:6] == PFX_CONT);
    end
  end

  // code point assembly for a completing byte
  always_comb begin
    case (exp_q)
      EXP_ONE:   cp = {10'd0, held_q[0][4:0], byte_i[5:0]};
      EXP_TWO:   cp = {5'd0, held_q[0][3:0], held_q[1][5:0], byte_i[5:0]};
      EXP_THREE: cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], byte_i[5:0]};
      default:   cp = '0;
    endcase
  end

  // next state and job
  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    exp_d  = exp_q;
    job_o  = '0;
    job_o.raw = held_q;

    if (exp_q != EXP_NONE && cont_ok) begin
      if (cnt_q >= exp_q) begin
        // sequence complete
        job_o.tail_vld = 1'b1;
        job_o.tail_cp  = cp;
        cnt_d = '0;
        exp_d = EXP_NONE;
      end else begin
        // hold the continuation
        if (cnt_q != 2'd3) begin
          held_d[cnt_q] = byte_i;
        end
        cnt_d = cnt_q + 2'd1;
        if (end_i) begin
          job_o.raw    = held_d;
          job_o.nr_raw = cnt_q + 2'd1;
          cnt_d = '0;
          exp_d = EXP_NONE;
        end
      end
    end else begin
      // broken sequence: flush what is held, then start over with this byte
      if (exp_q != EXP_NONE) begin
        job_o.nr_raw = cnt_q;
        cnt_d = '0;
        exp_d = EXP_NONE;
      end
      if (is_ascii) begin
        job_o.tail_vld = 1'b1;
        job_o.tail_cp  = CP_W'(byte_i);
      end else if (is_lead && !end_i) begin
        held_d[0] = byte_i;
        cnt_d = 2'd1;
        exp_d = fresh_exp;
      end else begin
        // stray byte, or a lead byte that ends the string
        job_o.tail_vld = 1'b1;
        job_o.tail_cp  = CP_W'(byte_i);
        job_o.tail_err = 1'b1;
      end
    end
  end

  assign push_o      = fire_i && (job_o.nr_raw != 2'd0 || job_o.tail_vld);
  assign stat_o.idle = (exp_q == EXP_NONE);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      exp_q <= EXP_NONE;
    end else if (fire_i) begin
      cnt_q <= cnt_d;
      exp_q <= exp_d;
    end
  end

  // held bytes, payload only
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

endmodule

### design/u2c_queue.sv
// ----------------------------------------------------------------------------
// u2c_queue
// Small job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module u2c_queue #(
  parameter int unsigned Depth = u2c_pkg::U2C_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u2c_pkg::job_t        job_i,
  input  logic                 pop_i,
  output u2c_pkg::job_t        head_o,
  output u2c_pkg::queue_stat_t stat_o
);
  import u2c_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### design/u2c_back.sv
// ----------------------------------------------------------------------------
// u2c_back
// Walks through each job one result per cycle into the output register, while that register is free or being read.
// ----------------------------------------------------------------------------
module u2c_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  u2c_pkg::job_t              head_i,
  input  logic                       head_vld_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u2c_pkg::CP_W-1:0]   cp_o,
  output logic                       err_o,
  output logic                       last_o
);
  import u2c_pkg::*;

  logic [1:0]      idx_q;
  logic [2:0]      total;
  logic            load, is_last;
  logic [CP_W-1:0] cur_cp;
  logic            cur_err;
  logic            valid_q;
  logic [CP_W-1:0] cp_q;
  logic            err_q, last_q;

  // pick the result at the current position of the job
  always_comb begin
    total   = {1'b0, head_i.nr_raw} + {2'b0, head_i.tail_vld};
    is_last = ({1'b0, idx_q} + 3'd1) == total;
    if (idx_q < head_i.nr_raw) begin
      cur_err = 1'b1;
      case (idx_q)
        2'd0:    cur_cp = CP_W'(head_i.raw[0]);
        2'd1:    cur_cp = CP_W'(head_i.raw[1]);
        default: cur_cp = CP_W'(head_i.raw[2]);
      endcase
    end else begin
      cur_err = head_i.tail_err;
      cur_cp  = head_i.tail_cp;
    end
  end

  assign load  = head_vld_i && (!valid_q || out_ready_i);
  assign pop_o = load && is_last;

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cur_cp;
      err_q  <= cur_err;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign cp_o        = cp_q;
  assign err_o       = err_q;
  assign last_o      = last_q;

endmodule

### design/utf8_to_codepoint_decoder_unit.sv
// An accepted byte's job is written into the job queue, then its first result
// is loaded into the output register. Throughput: one byte per cycle while each
// byte yields at most one result and the output is ready; a byte that flushes
// several results holds the output stage while they leave, and the 2-entry job queue absorbs the front meanwhile.
// Reset: asynchronous, active low; clears the pending sequence, queue and
// output valid. Held bytes are not cleared.
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_unit
// Streaming UTF-8 decoder: bytes in, code points (or flagged raw bytes) out.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit #(
  parameter int unsigned QueueDepth = u2c_pkg::U2C_QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [u2c_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tlast,  // string_end
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [u2c_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // [20:0] code_point
  output logic                                m_axis_tuser,  // raw_error
  output logic                                m_axis_tlast   // last_of_run
);
  import u2c_pkg::*;

  logic        s_fire, push, pop;
  job_t        job, head;
  front_stat_t front_stat;
  queue_stat_t queue_stat;
  logic [CP_W-1:0] cp;

  assign s_axis_tready = !queue_stat.full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // front: classify bytes into jobs
  u2c_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s_fire),
    .byte_i (s_axis_tdata[BYTE_W-1:0]),
    .end_i  (s_axis_tlast),
    .push_o (push),
    .job_o  (job),
    .stat_o (front_stat)
  );

  // job queue
  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (queue_stat)
  );

  // back: serialize results
  u2c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_vld_i  (!queue_stat.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cp_o        (cp),
    .err_o       (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W - CP_W){1'b0}}, cp};

  // checks

  // a byte that ends the string leaves no sequence pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> front_stat.idle)
    else $error("sequence still pending after string end");

  // flagged results are always single raw bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CP_W-1:BYTE_W] == '0)
    else $error("raw error result wider than a byte");

  // the back only pops a job that is present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !queue_stat.empty)
    else $error("pop from empty job queue");

endmodule

### verif/utf8_to_codepoint_decoder_unit_chk.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_unit_chk
// Watches both stream channels of the UTF-8 decoder. It decodes every
// accepted byte on its own, queues the code points and raw bytes that the
// byte should produce, and compares each output transaction against the
// oldest queued result.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              byte_valid_i,
  input  logic                              byte_ready_i,
  input  logic [u2c_pkg::TDATA_IN_W-1:0]    byte_data_i,   // [7:0] data_byte
  input  logic                              byte_end_i,    // string_end
  input  logic                              cp_valid_i,
  input  logic                              cp_ready_i,
  input  logic [u2c_pkg::TDATA_OUT_W-1:0]   cp_data_i,     // [20:0] code_point
  input  logic                              cp_raw_i,      // raw_error
  input  logic                              cp_last_i,     // last_of_run
  output int unsigned                       mismatch_cnt_o,
  output int unsigned                       pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import u2c_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            raw;
    logic            last;
  } cp_result_t;

  // expected output transactions, oldest first
  cp_result_t cp_expect_q[$];

  // decoder state: held lead/continuation bytes and continuations still due
  logic [BYTE_W-1:0] held_q [HOLD_N];
  logic [1:0]        held_n = 2'd0;
  logic [1:0]        need_n = EXP_NONE;

  // results of the byte being decoded
  logic [CP_W-1:0]   run_cp  [4];
  logic              run_raw [4];
  int                run_n;

  int unsigned       mismatches;

  function automatic void add_result(input logic [CP_W-1:0] cp, input logic raw);
    run_cp[run_n]  = cp;
    run_raw[run_n] = raw;
    run_n++;
  endfunction

  // emit all held bytes as flagged raw values, back to idle
  function automatic void flush_held();
    for (int i = 0; i < int'(held_n); i++) add_result(CP_W'(held_q[i]), 1'b1);
    held_n = 2'd0;
    need_n = EXP_NONE;
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic str_end);
    logic            taken;
    logic            cont_ok;
    logic [CP_W-1:0] cp;
    cp_result_t      res;
    taken = 1'b0;
    run_n = 0;

    // a sequence is pending: take a continuation or break it
    if (need_n != EXP_NONE) begin
      cont_ok = (b[7:6] == PFX_CONT);
      if (held_n == 2'd1 && held_q[0] == LEAD_F4) cont_ok = (b[7:4] == PFX_CONT_F4);
      if (cont_ok) begin
        taken = 1'b1;
        if (held_n >= need_n) begin
          case (need_n)
            EXP_ONE: cp = CP_W'(held_q[0] & 8'h1f);
            EXP_TWO: cp = CP_W'(held_q[0] & 8'h0f);
            default: cp = CP_W'(held_q[0] & 8'h07);
          endcase
          for (int i = 1; i < int'(held_n); i++) cp = (cp << 6) | CP_W'(held_q[i][5:0]);
          cp = (cp << 6) | CP_W'(b[5:0]);
          add_result(cp, 1'b0);
          held_n = 2'd0;
          need_n = EXP_NONE;
        end else begin
          held_q[held_n] = b;
          held_n++;
        end
      end else begin
        flush_held();
      end
    end

    // byte seen afresh: ASCII, a lead byte, or an undecodable byte
    if (!taken) begin
      if (!b[7]) begin
        add_result(CP_W'(b), 1'b0);
      end else if (b[7:5] == PFX_LEAD2) begin
        held_q[0] = b; held_n = 2'd1; need_n = EXP_ONE;
      end else if (b[7:4] == PFX_LEAD3) begin
        held_q[0] = b; held_n = 2'd1; need_n = EXP_TWO;
      end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
        held_q[0] = b; held_n = 2'd1; need_n = EXP_THREE;
      end else begin
        add_result(CP_W'(b), 1'b1);
      end
    end

    // end of string inside a sequence
    if (str_end && need_n != EXP_NONE) flush_held();

    for (int i = 0; i < run_n; i++) begin
      res.cp   = run_cp[i];
      res.raw  = run_raw[i];
      res.last = (i == run_n - 1);
      cp_expect_q.push_back(res);
    end
  endfunction

  // compare output transactions, then decode the accepted byte
  always @(posedge clk_i) begin : watch_proc
    cp_result_t want;
    if (rst_ni) begin
      if (cp_valid_i && cp_ready_i) begin
        if (cp_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result cp=%06h raw=%0b last=%0b", $time,
                     cp_data_i[CP_W-1:0], cp_raw_i, cp_last_i);
        end else begin
          want = cp_expect_q.pop_front();
          if (want.cp !== cp_data_i[CP_W-1:0] || want.raw !== cp_raw_i ||
              want.last !== cp_last_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp cp=%06h raw=%0b last=%0b, got cp=%06h raw=%0b last=%0b",
                       $time, want.cp, want.raw, want.last,
                       cp_data_i[CP_W-1:0], cp_raw_i, cp_last_i);
          end
        end
      end
      if (byte_valid_i && byte_ready_i) decode_byte(byte_data_i, byte_end_i);
    end
    mismatch_cnt_o <= mismatches;
    pending_cnt_o  <= unsigned'(cp_expect_q.size());
  end

endmodule

### verif/utf8_to_codepoint_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_unit_tb
// Drives byte strings into the UTF-8 decoder: a directed set of edge cases,
// then random characters, broken sequences and noise, with bursty input and
// a stalling output. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2c_pkg::*;

  localparam int unsigned NUM_BYTES      = 310;
  localparam int unsigned TIMEOUT_CYCLES = 200_000;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;

  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  logic [TDATA_IN_W-1:0]  byte_data  = '0;
  logic                   byte_end   = 1'b0;
  logic                   cp_valid;
  logic                   cp_ready   = 1'b0;
  logic [TDATA_OUT_W-1:0] cp_data;
  logic                   cp_raw;
  logic                   cp_last;

  int unsigned            mismatch_cnt;
  int unsigned            pending_cnt;

  int                     burst_left = 0;
  int                     gap_limit  = 3;
  int unsigned            cycle_cnt  = 0;

  // receiver stall pattern
  logic [5:0]             stall_phase = '0;
  logic [1:0]             stall_mode  = '0;

  always #6 clk = ~clk;

  utf8_to_codepoint_decoder_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (byte_valid),
    .s_axis_tready (byte_ready),
    .s_axis_tdata  (byte_data),
    .s_axis_tlast  (byte_end),
    .m_axis_tvalid (cp_valid),
    .m_axis_tready (cp_ready),
    .m_axis_tdata  (cp_data),
    .m_axis_tuser  (cp_raw),
    .m_axis_tlast  (cp_last)
  );

  utf8_to_codepoint_decoder_unit_chk u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .byte_valid_i   (byte_valid),
    .byte_ready_i   (byte_ready),
    .byte_data_i    (byte_data),
    .byte_end_i     (byte_end),
    .cp_valid_i     (cp_valid),
    .cp_ready_i     (cp_ready),
    .cp_data_i      (cp_data),
    .cp_raw_i       (cp_raw),
    .cp_last_i      (cp_last),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // output stalls: a new mode is drawn each time the stall phase counter wraps
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    cp_ready <= 1'b1;
      2'd1:    cp_ready <= 1'($urandom_range(0, 1));
      2'd2:    cp_ready <= (stall_phase % 6'd3 == 6'd0);
      default: cp_ready <= (stall_phase[3:0] > 4'd9);
    endcase
  end

  // one byte transaction, with a random gap between bursts
  task automatic send_byte(input logic [7:0] b, input logic str_end);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    byte_end   <= str_end;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    burst_left--;
  endtask

  // hold off input until every expected result has left the block
  task automatic wait_for_drain();
    byte_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // timeout
  initial begin
    while (cycle_cnt < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("utf8_to_codepoint_decoder_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] seq [4];
    int         len;
    int         kind;
    int         sent;
    bit         paused;
    sent   = 0;
    paused = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of the byte range, lone continuation, invalid lead
    send_byte(8'h00, 1'b0); send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'hff, 1'b0);
    // two- and three-byte characters
    send_byte(8'hc2, 1'b0); send_byte(8'ha9, 1'b0);
    send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hac, 1'b0);
    // highest code point, through an F4 lead
    send_byte(8'hf4, 1'b0); send_byte(8'h8f, 1'b0);
    send_byte(8'hbf, 1'b0); send_byte(8'hbf, 1'b0);
    // F4 followed by a continuation above 8F
    send_byte(8'hf4, 1'b0); send_byte(8'h90, 1'b0);
    // three held bytes broken by a new lead, which the string end flushes
    send_byte(8'hf0, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'hf0, 1'b1);
    // overlong form and surrogate
    send_byte(8'hc0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hed, 1'b0); send_byte(8'ha0, 1'b0); send_byte(8'h80, 1'b0);
    // string ends inside a sequence
    send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b1);
    wait_for_drain();

    // random characters, broken sequences and noise
    while (sent < NUM_BYTES) begin
      if ($urandom_range(0, 11) == 0)
        gap_limit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);

      kind = $urandom_range(0, 15);
      case (kind)
        0, 1, 2: begin
          seq[0] = 8'($urandom_range(0, 127));
          len    = 1;
        end
        3, 4, 5: begin
          seq[0] = 8'hc0 | 8'($urandom_range(0, 31));
          len    = 2;
        end
        6, 7, 8: begin
          seq[0] = 8'he0 | 8'($urandom_range(0, 15));
          len    = 3;
        end
        9, 10: begin
          seq[0] = 8'hf0 | 8'($urandom_range(0, 3));
          len    = 4;
        end
        11: begin
          seq[0] = LEAD_F4;
          len    = 4;
        end
        12, 13: begin
          len = $urandom_range(2, 4);
          case (len)
            2:       seq[0] = 8'hc0 | 8'($urandom_range(0, 31));
            3:       seq[0] = 8'he0 | 8'($urandom_range(0, 15));
            default: seq[0] = 8'hf0 | 8'($urandom_range(0, 4));
          endcase
        end
        default: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) seq[i] = 8'($urandom_range(0, 255));
        end
      endcase

      // continuations, F4 restricted to 80-8F on its first one
      if (kind >= 3 && kind <= 13) begin
        for (int i = 1; i < len; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
        if (seq[0] == LEAD_F4) seq[1] = 8'h80 | 8'($urandom_range(0, 15));
      end

      // broken: cut short or one continuation replaced by any byte
      if (kind == 12 || kind == 13) begin
        if ($urandom_range(0, 1) == 0)
          len = $urandom_range(1, len - 1);
        else
          seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end

      for (int i = 0; i < len; i++) begin
        send_byte(seq[i], $urandom_range(0, 19) == 0);
        sent++;
      end

      if (!paused && sent >= NUM_BYTES / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end

    wait_for_drain();
    repeat (8) @(posedge clk);

    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("utf8_to_codepoint_decoder_unit regression: pass");
    else
      $display("utf8_to_codepoint_decoder_unit regression: fail");
    $finish;
  end

endmodule

### files.f
design/u2c_pkg.sv
design/u2c_front.sv
design/u2c_queue.sv
design/u2c_back.sv
design/utf8_to_codepoint_decoder_unit.sv
verif/utf8_to_codepoint_decoder_unit_chk.sv
verif/utf8_to_codepoint_decoder_unit_tb.sv
